// ===== rtl/core/fit_policy_hole_allocator_core_defines.svh =====
// Assertion macros for the hole allocator core.
// Used by the top level only; needs no other file.
`ifndef FIT_POLICY_HOLE_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_POLICY_HOLE_ALLOCATOR_CORE_DEFINES_SVH
// Assert that a property holds outside reset.
`define FPHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert a property including reset cycles.
`define FPHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/fpha_pkg.sv =====
// Package for the hole allocator core: sizes, codes and sequencer states.
// Used by the top level of the core and by the testbench; depends on nothing.
package fpha_pkg;
  localparam int HoleEntries  = 32;
  localparam int LeaseEntries = 32;
  localparam int HIW = $clog2(HoleEntries);
  localparam int LIW = $clog2(LeaseEntries);
  localparam int HCW = $clog2(HoleEntries + 1);
  localparam int LCW = $clog2(LeaseEntries + 1);
  localparam logic [15:0] MEM_RESET = 16'd1000;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_NOFIT = 2'd1;
  localparam logic [1:0] CAUSE_FULL  = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_MEMSZ  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REL_CHK,   // check head lease
    S_REL_SCAN,  // search hole with lease start
    S_REL_SHIFT, // drop head lease
    S_FIND,      // scan holes for fit
    S_DECIDE,
    S_HSHIFT,    // open slot in hole table
    S_HSPLIT,    // write the remainder entry
    S_HMARK,     // mark the chosen hole as used
    S_LPOS,      // find lease insert position
    S_LSHIFT,
    S_LWRITE,
    S_COAL_RD0,  // load the first hole of the coalesce pass
    S_COAL_CMP,  // compare with the next hole
    S_COAL_SH,   // close the gap after a merge
    S_DONE
  } state_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction
endpackage

// ===== rtl/core/fpha_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// Depends on nothing.
module fpha_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/fit_policy_hole_allocator_core.sv =====
// Top level of the hole allocator core: sequencer, tables and counters.
// Depends on fpha_pkg, fpha_ram and the defines header.
//
// One item (tick) is accepted when start is high and busy is low; busy then
// stays high until the single result is shown for one cycle with done high.
// Results cannot be held off. One sequencer walks the hole RAM and the lease
// RAM through their single read ports, one entry at a time (read, then use or
// move). A tick first releases the leases that are due; a request then scans
// the holes, and a refused request also merges free neighbors, moving the
// entries behind each merge. Writing the pool size register reloads the hole
// table with a single write of entry zero; configure only
// while busy is low.
`include "fit_policy_hole_allocator_core_defines.svh"
module fit_policy_hole_allocator_core
  import fpha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] req_size,
  input  logic [15:0] req_lease,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        request_done,
  output logic        granted,
  output logic [1:0]  fail_cause,
  output logic [15:0] start_addr,
  output logic [5:0]  released_count,
  output logic [15:0] success_count,
  output logic [15:0] fail_count
);
  state_t state, state_next;

  // Configuration and persistent state.
  logic [1:0]  fit_policy;
  logic [HCW-1:0] hole_used;
  logic [LCW-1:0] lease_used;
  logic [31:0] clock_count;

  // Item registers.
  logic        it_mode;
  logic [15:0] it_size, it_lease;
  logic [HCW-1:0] idx;       // general hole index
  logic [LCW-1:0] lidx;      // lease index, insert position
  logic [LCW-1:0] lk;        // lease shift pointer (moving down)
  logic        phase;        // read then use phase of an entry
  logic        pick_valid;
  logic [HIW-1:0] pick;
  logic [15:0] pick_size, pick_start;
  logic [15:0] rel_start, rel_size;
  logic [HCW-1:0] coal_i;
  logic [15:0] coal_start, coal_size;

  // Hole RAM: {start, size}.
  logic            h_we;
  logic [HIW-1:0]  h_waddr, h_raddr;
  logic [31:0]     h_wdata, h_rdata;
  // Lease RAM: {start, size, expiry}.
  logic            l_we;
  logic [LIW-1:0]  l_waddr, l_raddr;
  logic [63:0]     l_wdata, l_rdata;

  fpha_ram #(.Width(32), .Depth(HoleEntries)) u_hole (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));
  fpha_ram #(.Width(64), .Depth(LeaseEntries)) u_lease (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  logic [15:0] h_st, h_sz, l_st, l_sz;
  logic [31:0] l_exp;
  assign h_st  = h_rdata[31:16];
  assign h_sz  = h_rdata[15:0];
  assign l_st  = l_rdata[63:48];
  assign l_sz  = l_rdata[47:32];
  assign l_exp = l_rdata[31:0];

  // Neighbor indexes used by the moves and scans.
  logic [HCW-1:0] idx_inc, idx_dec, coal_nxt, pick_nxt;
  logic [LCW-1:0] lidx_inc, lk_dec;
  assign idx_inc  = idx + HCW'(1);
  assign idx_dec  = idx - HCW'(1);
  assign coal_nxt = coal_i + HCW'(1);
  assign pick_nxt = {1'b0, pick} + HCW'(1);
  assign lidx_inc = lidx + LCW'(1);
  assign lk_dec   = lk - LCW'(1);

  logic [15:0] eff_lease;
  assign eff_lease = (it_lease == 16'd0) ? 16'd1 : it_lease;
  logic [31:0] remain;
  assign remain = l_exp - clock_count;
  logic fits;
  assign fits = (it_size != 16'd0) && (h_sz >= it_size);
  logic better;
  always_comb begin
    if (!pick_valid) better = 1'b1;
    else if (fit_policy == POLICY_BEST) better = h_sz < pick_size;
    else better = h_sz > pick_size;
  end
  logic rel_due, rel_hit, merge, table_full;
  assign rel_due    = (l_exp == clock_count);
  assign rel_hit    = (h_st == rel_start);
  assign merge      = (coal_size != 16'd0) && (h_sz != 16'd0);
  assign table_full = (hole_used >= HCW'(HoleEntries)) || (lease_used >= LCW'(LeaseEntries));

  logic cfg_mem;
  assign cfg_mem = cfg_we && (cfg_index == CFG_MEMSZ);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_REL_CHK;
      S_REL_CHK: begin
        if (!phase) begin
          if (lease_used == '0) state_next = it_mode ? S_FIND : S_DONE;
        end else if (rel_due) begin
          state_next = S_REL_SCAN;
        end else begin
          state_next = it_mode ? S_FIND : S_DONE;
        end
      end
      S_REL_SCAN: begin
        if (!phase) begin
          if (idx >= hole_used) state_next = S_REL_SHIFT;
        end else if (rel_hit) begin
          state_next = S_REL_SHIFT;
        end
      end
      S_REL_SHIFT: if (!phase && lidx_inc >= lease_used) state_next = S_REL_CHK;
      S_FIND: begin
        if (!phase) begin
          if (idx >= hole_used) state_next = S_DECIDE;
        end else if (fits && fit_policy == POLICY_FIRST) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!pick_valid || table_full) state_next = S_COAL_RD0;
        else state_next = S_HSHIFT;
      end
      S_HSHIFT: if (!phase && idx <= pick_nxt) state_next = S_HSPLIT;
      S_HSPLIT: state_next = S_HMARK;
      S_HMARK: state_next = S_LPOS;
      S_LPOS: begin
        if (!phase) begin
          if (lidx >= lease_used) state_next = S_LSHIFT;
        end else if (remain >= {16'd0, eff_lease}) begin
          state_next = S_LSHIFT;
        end
      end
      S_LSHIFT: if (!phase && lk <= lidx) state_next = S_LWRITE;
      S_LWRITE: state_next = S_DONE;
      S_COAL_RD0: begin
        if (!phase) begin
          if (coal_nxt >= hole_used) state_next = S_DONE;
        end else begin
          state_next = S_COAL_CMP;
        end
      end
      S_COAL_CMP: begin
        if (!phase) begin
          if (coal_nxt >= hole_used) state_next = S_DONE;
        end else if (merge) begin
          state_next = S_COAL_SH;
        end
      end
      S_COAL_SH: if (!phase && idx_inc >= hole_used) state_next = S_COAL_CMP;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the handshake.
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
  end

  // Read addresses: the data arrive in the phase after the read is issued.
  always_comb begin
    h_raddr = '0;
    l_raddr = '0;
    case (state)
      S_REL_SCAN:  h_raddr = idx[HIW-1:0];
      S_FIND:      h_raddr = idx[HIW-1:0];
      S_HSHIFT:    h_raddr = idx_dec[HIW-1:0];
      S_COAL_RD0:  h_raddr = coal_i[HIW-1:0];
      S_COAL_CMP:  h_raddr = coal_nxt[HIW-1:0];
      S_COAL_SH:   h_raddr = idx_inc[HIW-1:0];
      S_REL_SHIFT: l_raddr = lidx_inc[LIW-1:0];
      S_LPOS:      l_raddr = lidx[LIW-1:0];
      S_LSHIFT:    l_raddr = lk_dec[LIW-1:0];
      default: ;
    endcase
  end

  // Write ports: reset and the pool size write reload hole entry zero.
  always_comb begin
    h_we = 1'b0;
    h_waddr = '0;
    h_wdata = '0;
    l_we = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    if (rst) begin
      h_we = 1'b1;
      h_wdata = {16'd0, MEM_RESET};
    end else if (cfg_mem) begin
      h_we = 1'b1;
      h_wdata = {16'd0, cfg_data};
    end else begin
      case (state)
        S_REL_SCAN: begin
          if (phase && rel_hit) begin
            h_we = 1'b1;
            h_waddr = idx[HIW-1:0];
            h_wdata = {h_st, sat_add16(h_sz, rel_size)};
          end
        end
        S_REL_SHIFT: begin
          if (phase) begin
            l_we = 1'b1;
            l_waddr = lidx[LIW-1:0];
            l_wdata = l_rdata;
          end
        end
        S_HSHIFT: begin
          if (phase) begin
            h_we = 1'b1;
            h_waddr = idx[HIW-1:0];
            h_wdata = h_rdata;
          end
        end
        S_HSPLIT: begin
          h_we = 1'b1;
          h_waddr = pick_nxt[HIW-1:0];
          h_wdata = {pick_start + it_size, pick_size - it_size};
        end
        S_HMARK: begin
          h_we = 1'b1;
          h_waddr = pick;
          h_wdata = {pick_start, 16'd0};
        end
        S_LSHIFT: begin
          if (phase) begin
            l_we = 1'b1;
            l_waddr = lk[LIW-1:0];
            l_wdata = l_rdata;
          end
        end
        S_LWRITE: begin
          l_we = 1'b1;
          l_waddr = lidx[LIW-1:0];
          l_wdata = {pick_start, it_size, clock_count + {16'd0, eff_lease}};
        end
        S_COAL_CMP: begin
          if (phase && merge) begin
            h_we = 1'b1;
            h_waddr = coal_i[HIW-1:0];
            h_wdata = {coal_start, sat_add16(coal_size, h_sz)};
          end
        end
        S_COAL_SH: begin
          if (phase) begin
            h_we = 1'b1;
            h_waddr = idx[HIW-1:0];
            h_wdata = h_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      fit_policy <= POLICY_FIRST;
      hole_used <= HCW'(1);
      lease_used <= '0;
      clock_count <= '0;
      it_mode <= 1'b0;
      it_size <= '0;
      it_lease <= '0;
      idx <= '0;
      lidx <= '0;
      lk <= '0;
      pick_valid <= 1'b0;
      pick <= '0;
      pick_size <= '0;
      pick_start <= '0;
      rel_start <= '0;
      rel_size <= '0;
      coal_i <= '0;
      coal_start <= '0;
      coal_size <= '0;
      request_done <= 1'b0;
      granted <= 1'b0;
      fail_cause <= CAUSE_NONE;
      start_addr <= '0;
      released_count <= '0;
      success_count <= '0;
      fail_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == CFG_POLICY) fit_policy <= cfg_data[1:0];
      if (cfg_mem) begin
        hole_used <= HCW'(1);
        lease_used <= '0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            it_mode <= mode;
            it_size <= req_size;
            it_lease <= req_lease;
            clock_count <= clock_count + 32'd1;
            released_count <= '0;
            request_done <= mode;
            granted <= 1'b0;
            fail_cause <= CAUSE_NONE;
            start_addr <= '0;
            pick_valid <= 1'b0;
            phase <= 1'b0;
            idx <= '0;
            lidx <= '0;
          end
        end
        S_REL_CHK: begin
          if (!phase) begin
            if (lease_used != '0) phase <= 1'b1;
            else idx <= '0;
          end else begin
            phase <= 1'b0;
            idx <= '0;
            if (rel_due) begin
              if (released_count != 6'd63) released_count <= released_count + 6'd1;
              rel_start <= l_st;
              rel_size <= l_sz;
            end
          end
        end
        S_REL_SCAN: begin
          if (!phase) begin
            if (idx < hole_used) phase <= 1'b1;
            else lidx <= '0;
          end else begin
            phase <= 1'b0;
            if (rel_hit) lidx <= '0;
            else idx <= idx_inc;
          end
        end
        S_REL_SHIFT: begin
          // Move lease k+1 to k until the end, then drop the last slot.
          if (!phase) begin
            if (lidx_inc >= lease_used) lease_used <= lease_used - LCW'(1);
            else phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            lidx <= lidx_inc;
          end
        end
        S_FIND: begin
          if (!phase) begin
            if (idx < hole_used) phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (fits && better) begin
              pick_valid <= 1'b1;
              pick <= idx[HIW-1:0];
              pick_size <= h_sz;
              pick_start <= h_st;
            end
            idx <= idx_inc;
          end
        end
        S_DECIDE: begin
          phase <= 1'b0;
          coal_i <= '0;
          idx <= hole_used;
          if (!pick_valid || table_full) begin
            fail_cause <= pick_valid ? CAUSE_FULL : CAUSE_NOFIT;
            if (fail_count != 16'hFFFF) fail_count <= fail_count + 16'd1;
          end
        end
        S_HSHIFT: begin
          // Move hole k-1 to k, downward until just after the chosen hole.
          if (!phase) begin
            if (idx > pick_nxt) phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            idx <= idx_dec;
          end
        end
        S_HMARK: begin
          hole_used <= hole_used + HCW'(1);
          start_addr <= pick_start;
          granted <= 1'b1;
          if (success_count != 16'hFFFF) success_count <= success_count + 16'd1;
          lidx <= '0;
          phase <= 1'b0;
        end
        S_LPOS: begin
          if (!phase) begin
            if (lidx < lease_used) phase <= 1'b1;
            else lk <= lease_used;
          end else begin
            phase <= 1'b0;
            if (remain < {16'd0, eff_lease}) lidx <= lidx_inc;
            else lk <= lease_used;
          end
        end
        S_LSHIFT: begin
          // Move lease k-1 to k, downward until the insert position.
          if (!phase) begin
            if (lk > lidx) phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            lk <= lk_dec;
          end
        end
        S_LWRITE: lease_used <= lease_used + LCW'(1);
        S_COAL_RD0: begin
          if (!phase) begin
            if (coal_nxt < hole_used) phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            coal_start <= h_st;
            coal_size <= h_sz;
          end
        end
        S_COAL_CMP: begin
          if (!phase) begin
            if (coal_nxt < hole_used) phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (merge) begin
              coal_size <= sat_add16(coal_size, h_sz);
              idx <= coal_nxt;
            end else begin
              coal_start <= h_st;
              coal_size <= h_sz;
              coal_i <= coal_nxt;
            end
          end
        end
        S_COAL_SH: begin
          // Move hole k+1 to k until the end, then drop the last slot.
          if (!phase) begin
            if (idx_inc < hole_used) phase <= 1'b1;
            else hole_used <= hole_used - HCW'(1);
          end else begin
            phase <= 1'b0;
            idx <= idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  `FPHA_ASSERT(a_done_one_cycle, done |=> !done, "done held longer than one cycle")
  `FPHA_ASSERT(a_no_grant_tick, (done && !request_done) |-> !granted, "grant without request")
  `FPHA_ASSERT(a_cause_grant, (done && granted) |-> (fail_cause == CAUSE_NONE), "cause on grant")
endmodule

// ===== test/fit_policy_hole_allocator_core_test.sv =====
// Self-checking testbench for fit_policy_hole_allocator_core: directed and random ticks
// under several fit policies and memory sizes, checked against an in-bench allocator model.
// Depends on fpha_pkg and the core RTL only.
`timescale 1ns / 1ps
module fit_policy_hole_allocator_core_test;
  import fpha_pkg::*;

  localparam logic [1:0] POLICY_WORST = 2'd2;
  localparam logic [1:0] POLICY_ODD   = 2'd3;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic        mode;
    logic [15:0] size;
    logic [15:0] lease;
  } tick_t;

  typedef struct packed {
    logic        request_done;
    logic        granted;
    logic [1:0]  fail_cause;
    logic [15:0] start_addr;
    logic [5:0]  released_count;
    logic [15:0] success_count;
    logic [15:0] fail_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [15:0] req_size = '0;
  logic [15:0] req_lease = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_POLICY;
  logic [15:0] cfg_data = '0;
  logic done, request_done, granted;
  logic [1:0] fail_cause;
  logic [15:0] start_addr, success_count, fail_count;
  logic [5:0] released_count;

  fit_policy_hole_allocator_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_t    tick_q[$];
  outcome_t outcome_q[$];
  tick_t    drive_item;
  int       send_idle_pct = 11;
  int       errors = 0;

  // Allocator state mirrored by the predictor.
  logic [1:0]  fit_sel;
  logic [15:0] mem_words;
  logic [15:0] h_start[HoleEntries];
  logic [15:0] h_size[HoleEntries];
  int unsigned hole_n;
  logic [15:0] l_start[LeaseEntries];
  logic [15:0] l_size[LeaseEntries];
  logic [31:0] l_exp[LeaseEntries];
  int unsigned lease_n;
  logic [31:0] tick_count;
  logic [15:0] grant_sum, refuse_sum;

  function automatic logic [15:0] grow16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void clear_tables();
    hole_n = 1;
    lease_n = 0;
    h_start[0] = '0;
    h_size[0] = mem_words;
  endfunction

  function automatic void model_config(logic idx, logic [15:0] val);
    if (idx == CFG_POLICY) begin
      fit_sel = val[1:0];
    end else begin
      mem_words = val;
      clear_tables();
    end
  endfunction

  // Merge neighboring free holes in one left-to-right pass.
  function automatic void merge_holes();
    int unsigned i, k;
    i = 0;
    while (i + 1 < hole_n) begin
      if (h_size[i] > 0 && h_size[i+1] > 0) begin
        h_size[i] = grow16(h_size[i], h_size[i+1]);
        for (k = i + 1; k + 1 < hole_n; k++) begin
          h_start[k] = h_start[k+1];
          h_size[k] = h_size[k+1];
        end
        hole_n--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic outcome_t model_tick(tick_t t);
    outcome_t r;
    int unsigned rel, i, k, pos, h;
    int pick;
    logic [31:0] lease;
    logic [15:0] a;
    r = '0;
    rel = 0;
    pick = -1;
    tick_count++;
    // Return every lease that expires now.
    while (lease_n > 0 && l_exp[0] == tick_count) begin
      for (i = 0; i < hole_n; i++) begin
        if (h_start[i] == l_start[0]) begin
          h_size[i] = grow16(h_size[i], l_size[0]);
          break;
        end
      end
      for (k = 0; k + 1 < lease_n; k++) begin
        l_start[k] = l_start[k+1];
        l_size[k] = l_size[k+1];
        l_exp[k] = l_exp[k+1];
      end
      lease_n--;
      rel++;
    end
    r.released_count = rel > 63 ? 6'd63 : rel[5:0];
    if (t.mode) begin
      r.request_done = 1'b1;
      if (t.size != 0) begin
        for (i = 0; i < hole_n; i++) begin
          if (h_size[i] >= t.size) begin
            if (pick < 0) pick = i;
            else if (fit_sel == POLICY_BEST && h_size[i] < h_size[pick]) pick = i;
            else if (fit_sel != POLICY_BEST && h_size[i] > h_size[pick]) pick = i;
            if (fit_sel == POLICY_FIRST) break;
          end
        end
      end
      lease = (t.lease == 0) ? 32'd1 : {16'd0, t.lease};
      if (pick < 0) begin
        r.fail_cause = CAUSE_NOFIT;
      end else if (hole_n >= HoleEntries || lease_n >= LeaseEntries) begin
        r.fail_cause = CAUSE_FULL;
      end else begin
        h = pick;
        a = h_start[h];
        for (k = hole_n; k > h + 1; k--) begin
          h_start[k] = h_start[k-1];
          h_size[k] = h_size[k-1];
        end
        h_start[h+1] = a + t.size;
        h_size[h+1] = h_size[h] - t.size;
        h_size[h] = '0;
        hole_n++;
        pos = 0;
        while (pos < lease_n && (l_exp[pos] - tick_count) < lease) pos++;
        for (k = lease_n; k > pos; k--) begin
          l_start[k] = l_start[k-1];
          l_size[k] = l_size[k-1];
          l_exp[k] = l_exp[k-1];
        end
        l_start[pos] = a;
        l_size[pos] = t.size;
        l_exp[pos] = tick_count + lease;
        lease_n++;
        r.granted = 1'b1;
        r.start_addr = a;
      end
      if (r.granted) begin
        if (grant_sum != 16'hFFFF) grant_sum++;
      end else begin
        merge_holes();
        if (refuse_sum != 16'hFFFF) refuse_sum++;
      end
    end
    r.success_count = grant_sum;
    r.fail_count = refuse_sum;
    return r;
  endfunction

  // Driver: presents queued ticks; a transfer happens when start is high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcome_q.push_back(model_tick(drive_item));
      if (!start || !busy) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = tick_q.pop_front();
          start <= 1'b1;
          mode <= drive_item.mode;
          req_size <= drive_item.size;
          req_lease <= drive_item.lease;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is compared with the oldest prediction.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 {request_done, granted, fail_cause, start_addr, released_count,
                  success_count, fail_count});
        errors++;
      end else begin
        exp_r = outcome_q.pop_front();
        if (request_done !== exp_r.request_done) begin
          $display("%0t: request_done expected %0d actual %0d", $time,
                   exp_r.request_done, request_done);
          errors++;
        end
        if (granted !== exp_r.granted) begin
          $display("%0t: granted expected %0d actual %0d", $time, exp_r.granted, granted);
          errors++;
        end
        if (fail_cause !== exp_r.fail_cause) begin
          $display("%0t: fail_cause expected %0d actual %0d", $time,
                   exp_r.fail_cause, fail_cause);
          errors++;
        end
        if (start_addr !== exp_r.start_addr) begin
          $display("%0t: start_addr expected %0d actual %0d", $time,
                   exp_r.start_addr, start_addr);
          errors++;
        end
        if (released_count !== exp_r.released_count) begin
          $display("%0t: released_count expected %0d actual %0d", $time,
                   exp_r.released_count, released_count);
          errors++;
        end
        if (success_count !== exp_r.success_count) begin
          $display("%0t: success_count expected %0d actual %0d", $time,
                   exp_r.success_count, success_count);
          errors++;
        end
        if (fail_count !== exp_r.fail_count) begin
          $display("%0t: fail_count expected %0d actual %0d", $time,
                   exp_r.fail_count, fail_count);
          errors++;
        end
      end
    end
  end

  function automatic void add_tick(logic m, logic [15:0] s, logic [15:0] l);
    tick_t t;
    t.mode = m;
    t.size = s;
    t.lease = l;
    tick_q.push_back(t);
  endfunction

  // Mostly requests that fit the current memory with short leases, plus noise.
  function automatic void add_random_tick();
    int unsigned pick_s, pick_l, top;
    logic [15:0] s, l;
    top = (mem_words / 6) + 1;
    pick_s = $urandom_range(99);
    pick_l = $urandom_range(99);
    if (pick_s < 85) s = 16'($urandom_range(top, 1));
    else if (pick_s < 88) s = '0;
    else if (pick_s < 94) s = mem_words;
    else s = 16'($urandom);
    if (pick_l < 90) l = 16'($urandom_range(40, 0));
    else if (pick_l < 96) l = 16'($urandom_range(400, 41));
    else l = 16'($urandom);
    add_tick($urandom_range(99) < 85, s, l);
  endfunction

  task automatic wait_idle();
    while (tick_q.size() > 0 || outcome_q.size() > 0 || start || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(idx, val);
  endtask

  // Phase settings: policy and memory size, extremes included.
  logic [1:0]  phase_policy[8] = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_ODD,
                                   POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_FIRST};
  logic [15:0] phase_mem[8]    = '{16'd1000, 16'd1, 16'd65535, 16'd500,
                                   16'd300, 16'd2000, 16'd1000, 16'd40000};

  initial begin
    fit_sel = POLICY_FIRST;
    mem_words = MEM_RESET;
    tick_count = '0;
    grant_sum = '0;
    refuse_sum = '0;
    clear_tables();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset configuration.
    add_tick(1'b0, 16'hFFFF, 16'hFFFF);
    add_tick(1'b1, 16'd0, 16'd5);
    add_tick(1'b1, 16'd10, 16'd0);
    add_tick(1'b1, 16'd1001, 16'd3);
    add_tick(1'b1, 16'd100, 16'd3);
    add_tick(1'b1, 16'd200, 16'd2);
    add_tick(1'b0, 16'd0, 16'd0);
    add_tick(1'b1, 16'd50, 16'd1);
    add_tick(1'b1, 16'd60, 16'd1);
    add_tick(1'b1, 16'd690, 16'd4);
    add_tick(1'b1, 16'd1, 16'd1);
    add_tick(1'b0, 16'd0, 16'd0);
    add_tick(1'b1, 16'hFFFF, 16'd1);
    add_tick(1'b1, 16'd990, 16'hFFFF);
    add_tick(1'b1, 16'd10, 16'd2);
    add_tick(1'b1, 16'd10, 16'd2);
    for (int p = 0; p < 8; p++) begin
      if (p == 3) send_idle_pct = 50;
      if (p == 6) send_idle_pct = 0;
      if (p > 0) begin
        wait_idle();
        write_reg(CFG_POLICY, {14'd0, phase_policy[p]});
        write_reg(CFG_MEMSZ, phase_mem[p]);
      end
      // Largest block with the longest lease on the widest memory.
      if (p == 2) add_tick(1'b1, 16'hFFFF, 16'hFFFF);
      for (int n = 0; n < 205; n++) add_random_tick();
    end
    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1000ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fpha_pkg.sv
rtl/core/fpha_ram.sv
rtl/core/fit_policy_hole_allocator_core.sv
test/fit_policy_hole_allocator_core_test.sv
